// ===== rtl/bdq_pkg.sv =====
package bdq_pkg;

    // Default ring depth and fixed field widths
    localparam int DEPTH_DEF = 64;
    localparam int VALUE_W   = 32;
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;

    // Operation codes carried on s_axis_tuser
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4
    } bdq_op_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_EMPTY    = 2'd2,
        STATUS_NOTFOUND = 2'd3
    } bdq_status_t;

    // Control state
    typedef enum logic {
        S_IDLE,
        S_SCAN
    } bdq_state_t;

    // Commands broadcast to every cell of the chain
    typedef struct packed {
        logic push_front;  // take the neighbour's entry from the front side
        logic pop_front;   // take the neighbour's entry from the back side
        logic compare;     // load match flag from key comparison
        logic scan;        // shift match flags one cell towards the front
    } bdq_cell_ctrl_t;

endpackage

// ===== rtl/bdq_cell.sv =====
module bdq_cell (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  bdq_pkg::bdq_cell_ctrl_t              ctrl,
    input  logic                                 wr_back,
    input  logic                                 occupied,
    input  logic signed [bdq_pkg::VALUE_W-1:0]   new_value,
    input  logic signed [bdq_pkg::VALUE_W-1:0]   front_data,
    input  logic signed [bdq_pkg::VALUE_W-1:0]   back_data,
    input  logic                                 back_match,
    output logic signed [bdq_pkg::VALUE_W-1:0]   data_out,
    output logic                                 match_out
);

    logic signed [bdq_pkg::VALUE_W-1:0] data_reg;
    logic                               match_reg;

    // Entry storage: shifts with front pushes and pops, written on back push
    always_ff @(posedge aclk) begin
        if (ctrl.push_front) begin
            data_reg <= front_data;
        end else if (ctrl.pop_front) begin
            data_reg <= back_data;
        end else if (wr_back) begin
            data_reg <= new_value;
        end
    end

    // Match flag: compared in parallel, then shifted towards the front
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
        end else if (ctrl.compare) begin
            match_reg <= occupied && (data_reg == new_value);
        end else if (ctrl.scan) begin
            match_reg <= back_match;
        end
    end

    assign data_out  = data_reg;
    assign match_out = match_reg;

endmodule

// ===== rtl/bounded_deque_with_search.sv =====
// Bounded double-ended queue of signed 32-bit values with search. Entries sit
// in a chain of DEPTH cells, cell 0 holding the front. A front push or pop
// shifts every cell one place, a back push writes the cell at the current
// occupancy and a back pop only lowers the count; each is done in the accept
// cycle. A search compares every cell with the key in the accept cycle, then
// shifts the match flags towards the front one cell per cycle until the flag
// of the first match reaches cell 0 or every stored entry has been passed.
// Every result then passes through a one-entry pending stage into the output
// register, and the input stays closed while a scan runs or the pending stage
// is full. One result waiting on m_axis does not hold back the next
// transaction; a second one does, until the first is taken. Results appear in
// order, one per input transaction.
module bounded_deque_with_search #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int OUT_W = ((bdq_pkg::STATUS_W + 2 * CNT_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [bdq_pkg::VALUE_W-1:0]     s_axis_tdata,   // value
    input  logic [bdq_pkg::OP_W-1:0]        s_axis_tuser,   // op
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [OUT_W-1:0]                m_axis_tdata    // status, position, occupancy
);

    localparam int POS_LSB = bdq_pkg::STATUS_W;
    localparam int OCC_LSB = bdq_pkg::STATUS_W + CNT_W;

    bdq_pkg::bdq_state_t state_reg, state_next;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] pos_reg, pos_next;

    logic                          pend_valid_reg, pend_valid_next;
    bdq_pkg::bdq_status_t          pend_status_reg, pend_status_next;
    logic [CNT_W-1:0]              pend_pos_reg, pend_pos_next;
    logic [CNT_W-1:0]              pend_occ_reg, pend_occ_next;

    logic                          m_valid_reg;
    bdq_pkg::bdq_status_t          m_status_reg;
    logic [CNT_W-1:0]              m_pos_reg;
    logic [CNT_W-1:0]              m_occ_reg;

    bdq_pkg::bdq_cell_ctrl_t       cell_ctrl;
    logic                          push_back;
    logic                          accept;
    logic                          full;
    logic                          empty;
    logic                          scan_hit;
    logic                          scan_end;
    logic                          pend_move;
    bdq_pkg::bdq_op_t              op;

    logic signed [bdq_pkg::VALUE_W-1:0] value;
    logic signed [bdq_pkg::VALUE_W-1:0] data_w  [DEPTH];
    logic [DEPTH-1:0]                   match_w;

    assign op       = bdq_pkg::bdq_op_t'(s_axis_tuser);
    assign value    = s_axis_tdata;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign scan_hit = match_w[0];
    assign scan_end = (pos_reg >= count_reg);
    assign pend_move = pend_valid_reg && (!m_valid_reg || m_axis_tready);

    // Chain of entry cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [bdq_pkg::VALUE_W-1:0] front_d;
        logic signed [bdq_pkg::VALUE_W-1:0] back_d;
        logic                               back_m;

        if (i == 0) begin : g_first
            assign front_d = value;
        end else begin : g_mid_f
            assign front_d = data_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign back_d = data_w[i];
            assign back_m = 1'b0;
        end else begin : g_mid_b
            assign back_d = data_w[i+1];
            assign back_m = match_w[i+1];
        end

        bdq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (cell_ctrl),
            .wr_back    (push_back && (count_reg == CNT_W'(i))),
            .occupied   (CNT_W'(i) < count_reg),
            .new_value  (value),
            .front_data (front_d),
            .back_data  (back_d),
            .back_match (back_m),
            .data_out   (data_w[i]),
            .match_out  (match_w[i])
        );
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            bdq_pkg::S_IDLE: begin
                if (accept && (op == bdq_pkg::OP_SEARCH)) begin
                    state_next = bdq_pkg::S_SCAN;
                end
            end
            bdq_pkg::S_SCAN: begin
                if (scan_hit || scan_end) begin
                    state_next = bdq_pkg::S_IDLE;
                end
            end
            default: state_next = bdq_pkg::S_IDLE;
        endcase
    end

    // Outputs of the controller: cell commands, count, pending result
    always_comb begin
        s_axis_tready    = (state_reg == bdq_pkg::S_IDLE) && !pend_valid_reg;
        cell_ctrl        = '0;
        push_back        = 1'b0;
        count_next       = count_reg;
        pos_next         = pos_reg;
        pend_valid_next  = pend_valid_reg && !pend_move;
        pend_status_next = pend_status_reg;
        pend_pos_next    = pend_pos_reg;
        pend_occ_next    = pend_occ_reg;

        unique case (state_reg)
            bdq_pkg::S_IDLE: begin
                if (accept) begin
                    pend_status_next = bdq_pkg::STATUS_OK;
                    pend_pos_next    = '0;
                    unique case (op)
                        bdq_pkg::OP_PUSH_FRONT: begin
                            if (full) begin
                                pend_status_next = bdq_pkg::STATUS_FULL;
                            end else begin
                                cell_ctrl.push_front = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        bdq_pkg::OP_PUSH_BACK: begin
                            if (full) begin
                                pend_status_next = bdq_pkg::STATUS_FULL;
                            end else begin
                                push_back  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        bdq_pkg::OP_POP_FRONT: begin
                            if (empty) begin
                                pend_status_next = bdq_pkg::STATUS_EMPTY;
                            end else begin
                                cell_ctrl.pop_front = 1'b1;
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        bdq_pkg::OP_POP_BACK: begin
                            if (empty) begin
                                pend_status_next = bdq_pkg::STATUS_EMPTY;
                            end else begin
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        bdq_pkg::OP_SEARCH: begin
                            cell_ctrl.compare = 1'b1;
                            pos_next = CNT_W'(1);
                        end
                        default: ;  // unused codes: no operation
                    endcase
                    // searches post their result when the scan ends
                    pend_valid_next = (op != bdq_pkg::OP_SEARCH);
                    pend_occ_next   = count_next;
                end
            end
            bdq_pkg::S_SCAN: begin
                if (scan_hit) begin
                    pend_valid_next  = 1'b1;
                    pend_status_next = bdq_pkg::STATUS_OK;
                    pend_pos_next    = pos_reg;
                    pend_occ_next    = count_reg;
                end else if (scan_end) begin
                    pend_valid_next  = 1'b1;
                    pend_status_next = bdq_pkg::STATUS_NOTFOUND;
                    pend_pos_next    = '0;
                    pend_occ_next    = count_reg;
                end else begin
                    cell_ctrl.scan = 1'b1;
                    pos_next = pos_reg + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bdq_pkg::S_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            if (pend_move) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        pos_reg         <= pos_next;
        pend_status_reg <= pend_status_next;
        pend_pos_reg    <= pend_pos_next;
        pend_occ_reg    <= pend_occ_next;
        if (pend_move) begin
            m_status_reg <= pend_status_reg;
            m_pos_reg    <= pend_pos_reg;
            m_occ_reg    <= pend_occ_reg;
        end
    end

    // Result transaction packing
    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[bdq_pkg::STATUS_W-1:0] = m_status_reg;
        m_axis_tdata[POS_LSB +: CNT_W]      = m_pos_reg;
        m_axis_tdata[OCC_LSB +: CNT_W]      = m_occ_reg;
    end

    assign m_axis_tvalid = m_valid_reg;

endmodule

// ===== rtl/bdq_checker.sv =====
module bdq_checker #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEF,
    localparam int CNT_W = $clog2(DEPTH + 1),
    localparam int OUT_W = ((bdq_pkg::STATUS_W + 2 * CNT_W + 7) / 8) * 8
) (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [bdq_pkg::OP_W-1:0]    s_axis_tuser,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [OUT_W-1:0]            m_axis_tdata
);

    logic [bdq_pkg::STATUS_W-1:0] status;
    logic [CNT_W-1:0]             position;
    logic [CNT_W-1:0]             occupancy;

    assign status    = m_axis_tdata[bdq_pkg::STATUS_W-1:0];
    assign position  = m_axis_tdata[bdq_pkg::STATUS_W +: CNT_W];
    assign occupancy = m_axis_tdata[bdq_pkg::STATUS_W + CNT_W +: CNT_W];

    // Occupancy never exceeds the ring depth
    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (occupancy <= CNT_W'(DEPTH)))
        else $error("occupancy above depth");

    // A rejected push only happens when full, a rejected pop only when empty
    a_full_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
            ((status != bdq_pkg::STATUS_FULL) || (occupancy == CNT_W'(DEPTH))) &&
            ((status != bdq_pkg::STATUS_EMPTY) || (occupancy == '0)))
        else $error("full/empty status with inconsistent occupancy");

    // A reported position lies within the stored entries
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && (position != '0)) |->
            ((status == bdq_pkg::STATUS_OK) && (position <= occupancy)))
        else $error("search position out of range");

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // A search keeps the input closed after it is accepted
    a_search_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == bdq_pkg::OP_SEARCH))
            |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input reopened during a search");

endmodule

bind bounded_deque_with_search bdq_checker #(.DEPTH(DEPTH)) u_bdq_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/deque_check_pkg.sv =====
`timescale 1ns / 100ps

// Result prediction and checking for the bounded deque
package deque_check_pkg;

    import bdq_pkg::*;

    localparam int RING_DEPTH = DEPTH_DEF;
    localparam int COUNT_W    = $clog2(RING_DEPTH + 1);
    localparam int RESULT_W   = ((STATUS_W + 2 * COUNT_W + 7) / 8) * 8;

    typedef struct {
        bdq_status_t        status;
        logic [COUNT_W-1:0] position;
        logic [COUNT_W-1:0] occupancy;
    } deque_result_t;

    class deque_scoreboard;
        // shadow of the ring contents, front pointer and fill level
        logic [VALUE_W-1:0] ring [RING_DEPTH];
        int unsigned        head;
        int unsigned        fill;
        deque_result_t      awaited [$];
        int unsigned        accepted;
        int unsigned        errors;

        function new();
            head     = 0;
            fill     = 0;
            accepted = 0;
            errors   = 0;
        endfunction

        // Apply one accepted input transaction and queue its result
        function void note_input(logic [OP_W-1:0] op, logic [VALUE_W-1:0] key);
            deque_result_t r;
            r.status   = STATUS_OK;
            r.position = '0;
            case (op)
                OP_PUSH_FRONT: begin
                    if (fill >= RING_DEPTH) begin
                        r.status = STATUS_FULL;
                    end else begin
                        head       = (head + RING_DEPTH - 1) % RING_DEPTH;
                        ring[head] = key;
                        fill++;
                    end
                end
                OP_PUSH_BACK: begin
                    if (fill >= RING_DEPTH) begin
                        r.status = STATUS_FULL;
                    end else begin
                        ring[(head + fill) % RING_DEPTH] = key;
                        fill++;
                    end
                end
                OP_POP_FRONT: begin
                    if (fill == 0) begin
                        r.status = STATUS_EMPTY;
                    end else begin
                        head = (head + 1) % RING_DEPTH;
                        fill--;
                    end
                end
                OP_POP_BACK: begin
                    if (fill == 0)
                        r.status = STATUS_EMPTY;
                    else
                        fill--;
                end
                OP_SEARCH: begin
                    // first match counted from the front, 1-based
                    r.status = STATUS_NOTFOUND;
                    for (int i = 0; i < fill; i++) begin
                        if (ring[(head + i) % RING_DEPTH] == key) begin
                            r.status   = STATUS_OK;
                            r.position = COUNT_W'(i + 1);
                            break;
                        end
                    end
                end
                default: ;  // unused codes do nothing
            endcase
            r.occupancy = COUNT_W'(fill);
            awaited.push_back(r);
            accepted++;
        endfunction

        // Compare one output transaction against the oldest prediction
        function void check_result(logic [RESULT_W-1:0] data);
            deque_result_t      want;
            bdq_status_t        got_status;
            logic [COUNT_W-1:0] got_position;
            logic [COUNT_W-1:0] got_occupancy;
            got_status    = bdq_status_t'(data[STATUS_W-1:0]);
            got_position  = data[STATUS_W +: COUNT_W];
            got_occupancy = data[STATUS_W + COUNT_W +: COUNT_W];
            if (awaited.size() == 0) begin
                $error("unexpected result transaction, tdata %h", data);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got_status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                errors++;
            end
            if (got_position !== want.position) begin
                $error("position: expected %0d, got %0d", want.position, got_position);
                errors++;
            end
            if (got_occupancy !== want.occupancy) begin
                $error("occupancy: expected %0d, got %0d", want.occupancy, got_occupancy);
                errors++;
            end
        endfunction
    endclass

endpackage

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    import bdq_pkg::*;
    import deque_check_pkg::*;

    localparam int RANDOM_ITEMS  = 1625;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int HOLD_AT       = 400;   // accepted inputs before the long output stall
    localparam int HOLD_CYCLES   = 300;
    localparam int PAUSE_AT      = 1200;  // random item at which the sender drains the block
    localparam int DRAIN_CYCLES  = 150;
    localparam int IDLE_PERCENT  = 35;

    // op mix per block of random transactions
    localparam int MIX    = 0;
    localparam int GROW   = 1;
    localparam int SHRINK = 2;

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [VALUE_W-1:0]  s_axis_tdata  = '0;   // value
    logic [OP_W-1:0]     s_axis_tuser  = '0;   // op
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [RESULT_W-1:0] m_axis_tdata;         // status, position, occupancy

    deque_scoreboard sb = new();
    bit              quiet = 1'b0;  // no idling on either side
    int unsigned     cycle_count = 0;

    bounded_deque_with_search #(
        .DEPTH(RING_DEPTH)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock and reset
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    // Offer one transaction, with random idle cycles ahead of it
    task automatic send_item(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] key);
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= key;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        sb.note_input(op, key);
    endtask

    // Extremes, a small pool for duplicates, or anything
    function automatic logic [VALUE_W-1:0] any_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3, 4: return VALUE_W'($urandom_range(0, 7));
            default: return $urandom();
        endcase
    endfunction

    // Mostly a value that is stored, so searches hit at every depth
    function automatic logic [VALUE_W-1:0] search_key();
        if (sb.fill != 0 && $urandom_range(0, 99) < 60)
            return sb.ring[(sb.head + $urandom_range(0, sb.fill - 1)) % RING_DEPTH];
        return any_value();
    endfunction

    function automatic logic [OP_W-1:0] pick_op(int bias);
        int r;
        int grow_pct;
        r = $urandom_range(0, 99);
        if (r < 2)
            return OP_W'($urandom_range(OP_SEARCH + 1, (1 << OP_W) - 1));
        if (r < 27)
            return OP_SEARCH;
        grow_pct = (bias == GROW) ? 80 : (bias == SHRINK) ? 20 : 50;
        if ($urandom_range(0, 99) < grow_pct)
            return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    // Result side: check, then choose tready for the next cycle
    initial begin : sink
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (!held && sb.accepted >= HOLD_AT) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);
            end
        end
    end

    // Input side: directed transactions, then random ones
    initial begin : source
        int              bias;
        logic [OP_W-1:0] op;
        bias = MIX;
        wait (aresetn);
        @(posedge aclk);

        // empty queue: both pops, search and the unused codes
        send_item(OP_POP_FRONT, 32'h0000_0000);
        send_item(OP_POP_BACK, 32'hffff_ffff);
        send_item(OP_SEARCH, 32'h0000_0000);
        send_item(OP_W'(5), 32'hffff_ffff);
        send_item(OP_W'(6), 32'h0000_0000);
        send_item(OP_W'(7), 32'h8000_0000);
        // extremes from both ends: ffffffff 80000000 7fffffff 00000000
        send_item(OP_PUSH_BACK, 32'h7fff_ffff);
        send_item(OP_PUSH_FRONT, 32'h8000_0000);
        send_item(OP_PUSH_BACK, 32'h0000_0000);
        send_item(OP_PUSH_FRONT, 32'hffff_ffff);
        send_item(OP_SEARCH, 32'hffff_ffff);
        send_item(OP_SEARCH, 32'h0000_0000);
        send_item(OP_SEARCH, 32'h7fff_ffff);
        send_item(OP_SEARCH, 32'd12345);
        // duplicate at the back, the first match must win
        send_item(OP_PUSH_BACK, 32'h8000_0000);
        send_item(OP_SEARCH, 32'h8000_0000);
        // pop down to one entry, then to empty
        send_item(OP_POP_BACK, 32'h0000_0000);
        send_item(OP_POP_FRONT, 32'h0000_0000);
        send_item(OP_POP_BACK, 32'h0000_0000);
        send_item(OP_POP_FRONT, 32'h0000_0000);
        send_item(OP_SEARCH, 32'h7fff_ffff);
        send_item(OP_POP_BACK, 32'h0000_0000);
        send_item(OP_SEARCH, 32'h7fff_ffff);
        send_item(OP_POP_FRONT, 32'h0000_0000);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // blocks that fill to the brim, drain to empty, or wander
            if (n % 100 == 0) begin
                case ((n / 100) % 6)
                    0, 1:    bias = GROW;
                    3, 4:    bias = SHRINK;
                    default: bias = MIX;
                endcase
            end
            quiet = (n >= 700 && n < 1000);
            if (n == PAUSE_AT) begin
                s_axis_tvalid <= 1'b0;
                do @(posedge aclk); while (sb.awaited.size() != 0);
            end
            op = pick_op(bias);
            send_item(op, (op == OP_SEARCH) ? search_key() : any_value());
        end
        s_axis_tvalid <= 1'b0;
        quiet = 1'b0;

        do @(posedge aclk); while (sb.awaited.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.awaited.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/bdq_pkg.sv
rtl/bdq_cell.sv
rtl/bounded_deque_with_search.sv
rtl/bdq_checker.sv
verif/deque_check_pkg.sv
verif/tb.sv
